>>> sv/temstat_pkg.sv
// Package: shared constants and command/status types for the edge manifold stats unit.
package temstat_pkg;

    localparam int VERTEX_BITS = 16;
    localparam int SLOT_BITS   = 12;
    localparam int EDGE_SLOTS  = 1 << SLOT_BITS;
    localparam int KEY_BITS    = 2 * VERTEX_BITS;
    localparam int CNT_BITS    = 2;
    localparam int STAT_BITS   = 13;
    localparam int ENTRY_BITS  = 1 + KEY_BITS + CNT_BITS;
    localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
    localparam logic [CNT_BITS-1:0] COUNT_ONE   = 2'd1;
    localparam logic [CNT_BITS-1:0] COUNT_TWO   = 2'd2;
    localparam logic [CNT_BITS-1:0] COUNT_THREE = 2'd3;

    typedef struct packed {
        logic            load;     // capture triangle
        logic [1:0]      edge_sel; // which edge to hash
        logic            hash_lo;  // first partial product step
        logic            hash_hi;  // second partial product step
        logic            hash_fin; // fold and form home slot
        logic            rd;       // issue table read at probe slot
        logic            update;   // apply probe result
        logic            clr;      // clearing sweep step
        logic            clr_start;
        logic            emit;     // capture summary, reset counters
    } temstat_cmd_t;

    typedef struct packed {
        logic            probe_done; // edge settled (inserted, counted or dropped)
        logic            clr_done;
        logic            last;
    } temstat_sts_t;

endpackage

>>> sv/temstat_if.sv
// Interface: valid/ready channel carrying a payload of parameterized type.
interface temstat_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/temstat_ram.sv
// Generic single-port RAM with registered read.
module temstat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> sv/temstat_ctrl.sv
// Controller: sequences edge hashing, table probes, summary and clearing sweep.
module temstat_ctrl
    import temstat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         out_busy,
    input  temstat_sts_t sts,
    output temstat_cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_H1   = 3'd1;
    localparam logic [2:0] S_H2   = 3'd2;
    localparam logic [2:0] S_H3   = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;
    localparam logic [2:0] S_CLR  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] edge_reg, edge_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            edge_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        edge_next    = edge_reg;
        cmd          = '0;
        cmd.edge_sel = edge_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    edge_next  = 2'd0;
                    state_next = S_H1;
                end
            end
            S_H1:
            begin
                cmd.hash_lo = 1'b1;
                state_next  = S_H2;
            end
            S_H2:
            begin
                cmd.hash_hi = 1'b1;
                state_next  = S_H3;
            end
            S_H3:
            begin
                cmd.hash_fin = 1'b1;
                state_next   = S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                if (!sts.probe_done)
                    state_next = S_RD;
                else if (edge_reg != 2'd2)
                begin
                    edge_next  = edge_reg + 2'd1;
                    state_next = S_H1;
                end
                else if (sts.last)
                    state_next = S_EMIT;
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (!out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.clr_start = 1'b1;
                    state_next    = S_CLR;
                end
            end
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> sv/temstat_dp.sv
// Datapath: edge key, hash, probe table, use counters and summary register.
module temstat_dp
    import temstat_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  temstat_cmd_t           cmd,
    output temstat_sts_t           sts,
    input  logic [VERTEX_BITS-1:0] corner_a,
    input  logic [VERTEX_BITS-1:0] corner_b,
    input  logic [VERTEX_BITS-1:0] corner_c,
    input  logic                   last_face,
    output logic [STAT_BITS-1:0]   edge_total,
    output logic [STAT_BITS-1:0]   open_edges,
    output logic [STAT_BITS-1:0]   non_manifold_edges,
    output logic                   closed_flag,
    output logic                   manifold_flag,
    output logic                   table_full
);
    logic [VERTEX_BITS-1:0] a_reg, b_reg, c_reg;
    logic                   last_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [63:0]            prod_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [SLOT_BITS:0]     probes_reg;
    logic [SLOT_BITS:0]     clr_reg;
    logic [STAT_BITS:0]     distinct_reg, once_reg, twice_reg, over_reg;
    logic                   ovf_reg;
    logic [VERTEX_BITS-1:0] eu, ev;
    logic [KEY_BITS-1:0]    key_next;
    logic [63:0]            fold;
    logic                   ram_we;
    logic [SLOT_BITS-1:0]   ram_addr;
    logic [ENTRY_BITS-1:0]  ram_wdata, ram_rdata;
    logic                   hit_valid, key_match;
    logic [CNT_BITS-1:0]    cnt_rd;

    always_comb
    begin
        case (cmd.edge_sel)
            2'd0:    begin eu = a_reg; ev = b_reg; end
            2'd1:    begin eu = b_reg; ev = c_reg; end
            default: begin eu = c_reg; ev = a_reg; end
        endcase
        key_next = (eu > ev) ? {ev, eu} : {eu, ev};
    end

    // Table entry: {valid, key, use count}; the sweep writes all-zero entries.
    assign fold      = prod_reg ^ (prod_reg >> 29);
    assign hit_valid = ram_rdata[ENTRY_BITS-1];
    assign key_match = (ram_rdata[KEY_BITS+CNT_BITS-1:CNT_BITS] == key_reg);
    assign cnt_rd    = ram_rdata[CNT_BITS-1:0];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = slot_reg;
        ram_wdata = {1'b1, key_reg, COUNT_ONE};
        if (cmd.clr)
        begin
            ram_addr  = clr_reg[SLOT_BITS-1:0];
            ram_wdata = '0;
            ram_we    = !clr_reg[SLOT_BITS];
        end
        else if (cmd.update)
        begin
            if (!hit_valid)
                ram_we = 1'b1;
            else if (key_match && cnt_rd != COUNT_THREE)
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, key_reg, (cnt_rd == COUNT_ONE) ? COUNT_TWO : COUNT_THREE};
            end
        end
    end

    temstat_ram #(.WIDTH(ENTRY_BITS), .DEPTH(EDGE_SLOTS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign sts.probe_done = !hit_valid || key_match ||
                            (probes_reg == (SLOT_BITS+1)'(EDGE_SLOTS - 1));
    assign sts.clr_done   = clr_reg[SLOT_BITS];
    assign sts.last       = last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= corner_a;
            b_reg    <= corner_b;
            c_reg    <= corner_c;
            last_reg <= last_face;
        end
        if (cmd.hash_lo)
        begin
            key_reg  <= key_next;
            prod_reg <= 64'(key_next[VERTEX_BITS-1:0] * HASH_MULT);
        end
        if (cmd.hash_hi)
            prod_reg <= prod_reg + 64'({key_reg[KEY_BITS-1:VERTEX_BITS], 32'd0} * HASH_MULT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            slot_reg     <= '0;
            probes_reg   <= '0;
            distinct_reg <= '0;
            once_reg     <= '0;
            twice_reg    <= '0;
            over_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.hash_fin)
            begin
                slot_reg   <= fold[SLOT_BITS-1:0];
                probes_reg <= '0;
            end
            if (cmd.update)
            begin
                if (!hit_valid)
                begin
                    distinct_reg <= distinct_reg + 1'b1;
                    once_reg     <= once_reg + 1'b1;
                end
                else if (key_match)
                begin
                    if (cnt_rd == COUNT_ONE)
                    begin
                        once_reg  <= once_reg - 1'b1;
                        twice_reg <= twice_reg + 1'b1;
                    end
                    else if (cnt_rd == COUNT_TWO)
                    begin
                        twice_reg <= twice_reg - 1'b1;
                        over_reg  <= over_reg + 1'b1;
                    end
                end
                else if (probes_reg == (SLOT_BITS+1)'(EDGE_SLOTS - 1))
                    ovf_reg <= 1'b1;
                else
                begin
                    slot_reg   <= slot_reg + 1'b1;
                    probes_reg <= probes_reg + 1'b1;
                end
            end
            if (cmd.emit)
            begin
                distinct_reg <= '0;
                once_reg     <= '0;
                twice_reg    <= '0;
                over_reg     <= '0;
                ovf_reg      <= 1'b0;
            end
            if (cmd.clr_start)
                clr_reg <= '0;
            else if (cmd.clr && !clr_reg[SLOT_BITS])
                clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            edge_total         <= distinct_reg[STAT_BITS] ? '1 : distinct_reg[STAT_BITS-1:0];
            open_edges         <= once_reg[STAT_BITS] ? '1 : once_reg[STAT_BITS-1:0];
            non_manifold_edges <= over_reg[STAT_BITS] ? '1 : over_reg[STAT_BITS-1:0];
            closed_flag        <= (once_reg == '0) && (over_reg == '0);
            manifold_flag      <= (over_reg == '0);
            table_full         <= ovf_reg;
        end
    end

`ifndef SYNTHESIS
    a_cnt_sum: assert property (@(posedge clk) disable iff (!rst_n)
        distinct_reg == once_reg + twice_reg + over_reg)
        else $error("counter sum mismatch");
    a_no_upd_clr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !cmd.clr)
        else $error("table update during clear");
    a_emit_reset: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> distinct_reg == '0)
        else $error("counters not cleared after summary");
`endif
endmodule

>>> sv/triangle_edge_manifold_stats_unit.sv
// Top level: triangle edge manifold statistics unit.
// Per edge: hash steps H1, H2 and H3, then a table read and an update per probe;
// each collision adds another read and update at the next slot (table port bound).
// A last triangle adds the summary transfer and a clearing sweep.
// Reset (rst_n low, async) clears counters and control, then runs the same
// sweep over the edge table before the first input transfer.
module triangle_edge_manifold_stats_unit
    import temstat_pkg::*;
(
    input logic clk,
    input logic rst_n,
    temstat_if.sink   in_ch,
    temstat_if.source out_ch
);
    temstat_cmd_t cmd;
    temstat_sts_t sts;
    logic         out_valid_reg;
    logic [STAT_BITS-1:0] edge_total, open_edges, non_manifold_edges;
    logic closed_flag, manifold_flag, table_full;

    // Hold the summary until the sink takes it; block a new one meanwhile.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    temstat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_busy (out_valid_reg),
        .sts      (sts),
        .cmd      (cmd)
    );

    temstat_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .corner_a           (in_ch.data.corner_a),
        .corner_b           (in_ch.data.corner_b),
        .corner_c           (in_ch.data.corner_c),
        .last_face          (in_ch.data.last_face),
        .edge_total         (edge_total),
        .open_edges         (open_edges),
        .non_manifold_edges (non_manifold_edges),
        .closed_flag        (closed_flag),
        .manifold_flag      (manifold_flag),
        .table_full         (table_full)
    );

    assign out_ch.valid                   = out_valid_reg;
    assign out_ch.data.edge_total         = edge_total;
    assign out_ch.data.open_edges         = open_edges;
    assign out_ch.data.non_manifold_edges = non_manifold_edges;
    assign out_ch.data.closed_flag        = closed_flag;
    assign out_ch.data.manifold_flag      = manifold_flag;
    assign out_ch.data.table_full         = table_full;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("summary dropped while stalled");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg)
        else $error("summary overwritten");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |-> !in_ch.ready)
        else $error("input taken during clear");
`endif
endmodule

>>> tb/temstat_tb_pkg.sv
`timescale 1ns / 100ps
// Payload types for the triangle and summary channels of the edge stats testbench.
package temstat_tb_pkg;

    import temstat_pkg::*;

    typedef struct packed {
        logic [VERTEX_BITS-1:0] corner_a;
        logic [VERTEX_BITS-1:0] corner_b;
        logic [VERTEX_BITS-1:0] corner_c;
        logic                   last_face;
    } tri_face_t;

    typedef struct packed {
        logic [STAT_BITS-1:0] edge_total;
        logic [STAT_BITS-1:0] open_edges;
        logic [STAT_BITS-1:0] non_manifold_edges;
        logic                 closed_flag;
        logic                 manifold_flag;
        logic                 table_full;
    } mesh_summary_t;

endpackage

>>> tb/temstat_checker.sv
`timescale 1ns / 100ps
// Checker: watches both channels, tracks edge use per mesh and compares each summary.
module temstat_checker
    import temstat_pkg::*;
    import temstat_tb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    temstat_if   face_ch,
    temstat_if   stat_ch,
    output int   errors,
    output int   pending,
    output int   summaries_seen,
    output int   overflow_meshes
);

    logic [1:0]    use_of_edge [bit [KEY_BITS-1:0]];
    int            once_cnt;
    int            twice_cnt;
    int            over_cnt;
    logic          dropped;
    mesh_summary_t summary_queue[$];

    assign pending = summary_queue.size();

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    task automatic tally_edge(input logic [VERTEX_BITS-1:0] u, input logic [VERTEX_BITS-1:0] v);
        bit [KEY_BITS-1:0] key;
        key = (u <= v) ? {u, v} : {v, u};
        if (!use_of_edge.exists(key))
        begin
            if (use_of_edge.num() >= EDGE_SLOTS)
            begin
                dropped = 1'b1;
            end
            else
            begin
                use_of_edge[key] = COUNT_ONE;
                once_cnt++;
            end
        end
        else if (use_of_edge[key] == COUNT_ONE)
        begin
            use_of_edge[key] = COUNT_TWO;
            once_cnt--;
            twice_cnt++;
        end
        else if (use_of_edge[key] == COUNT_TWO)
        begin
            use_of_edge[key] = COUNT_THREE;
            twice_cnt--;
            over_cnt++;
        end
    endtask

    function automatic logic [STAT_BITS-1:0] clip13(input int x);
        return (x > 8191) ? 13'd8191 : x[STAT_BITS-1:0];
    endfunction

    task automatic clear_mesh();
        use_of_edge.delete();
        once_cnt  = 0;
        twice_cnt = 0;
        over_cnt  = 0;
        dropped   = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mesh_summary_t want;
        mesh_summary_t got;
        tri_face_t     f;
        if (!rst_n)
        begin
            clear_mesh();
            summary_queue.delete();
            errors          = 0;
            summaries_seen  <= 0;
            overflow_meshes <= 0;
        end
        else
        begin
            if (face_ch.valid && face_ch.ready)
            begin
                f = face_ch.data;
                tally_edge(f.corner_a, f.corner_b);
                tally_edge(f.corner_b, f.corner_c);
                tally_edge(f.corner_c, f.corner_a);
                if (f.last_face)
                begin
                    want.edge_total         = clip13(use_of_edge.num());
                    want.open_edges         = clip13(once_cnt);
                    want.non_manifold_edges = clip13(over_cnt);
                    want.closed_flag        = (once_cnt == 0) && (over_cnt == 0);
                    want.manifold_flag      = (over_cnt == 0);
                    want.table_full         = dropped;
                    if (dropped)
                    begin
                        overflow_meshes <= overflow_meshes + 1;
                    end
                    summary_queue.insert(summary_queue.size(), want);
                    clear_mesh();
                end
            end
            if (stat_ch.valid && stat_ch.ready)
            begin
                got = stat_ch.data;
                summaries_seen <= summaries_seen + 1;
                if (summary_queue.size() == 0)
                begin
                    report("summary with no mesh pending");
                end
                else
                begin
                    want = summary_queue.pop_front();
                    if (got.edge_total !== want.edge_total)
                        report($sformatf("edge_total %0d, want %0d",
                                         got.edge_total, want.edge_total));
                    if (got.open_edges !== want.open_edges)
                        report($sformatf("open_edges %0d, want %0d",
                                         got.open_edges, want.open_edges));
                    if (got.non_manifold_edges !== want.non_manifold_edges)
                        report($sformatf("non_manifold_edges %0d, want %0d",
                                         got.non_manifold_edges, want.non_manifold_edges));
                    if (got.closed_flag !== want.closed_flag)
                        report($sformatf("closed_flag %0b, want %0b",
                                         got.closed_flag, want.closed_flag));
                    if (got.manifold_flag !== want.manifold_flag)
                        report($sformatf("manifold_flag %0b, want %0b",
                                         got.manifold_flag, want.manifold_flag));
                    if (got.table_full !== want.table_full)
                        report($sformatf("table_full %0b, want %0b",
                                         got.table_full, want.table_full));
                end
            end
        end
    end

endmodule

>>> tb/triangle_edge_manifold_stats_unit_test.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, triangle stimulus and the final verdict.
module triangle_edge_manifold_stats_unit_test;

    import temstat_pkg::*;
    import temstat_tb_pkg::*;

    // Every mesh end costs a full clearing sweep, so the guard allows a sweep
    // after each triangle with room to spare.
    localparam longint CYCLE_LIMIT  = 40_000_000;
    localparam int     RANDOM_ITEMS = 650;
    localparam int     SWEEP_CYCLES = 4097;

    logic clk;
    logic rst_n;
    logic quiet;        // suppress random idling on both sides
    longint cycles = 0;
    int   errors;
    int   pending;
    int   summaries_seen;
    int   overflow_meshes;
    int   faces_sent;

    temstat_if #(.payload_t(tri_face_t))     face_ch ();
    temstat_if #(.payload_t(mesh_summary_t)) stat_ch ();

    triangle_edge_manifold_stats_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (face_ch.sink),
        .out_ch (stat_ch.source)
    );

    temstat_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .face_ch         (face_ch),
        .stat_ch         (stat_ch),
        .errors          (errors),
        .pending         (pending),
        .summaries_seen  (summaries_seen),
        .overflow_meshes (overflow_meshes)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Receiver stalls at random about 22 percent of the time, except in quiet stretches.
    always @(posedge clk)
    begin
        stat_ch.ready <= quiet || ($urandom_range(99) >= 22);
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("triangle_edge_manifold_stats_unit_test: errors");
            $finish;
        end
    end

    // Offer one triangle and hold it until the transfer, then maybe idle a while.
    task automatic send_face(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input logic last);
        face_ch.valid <= 1'b1;
        face_ch.data  <= '{corner_a: a, corner_b: b, corner_c: c, last_face: last};
        do
            @(posedge clk);
        while (!face_ch.ready);
        faces_sent++;
        if (!quiet && $urandom_range(99) < 22)
        begin
            face_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Closed tetrahedron on four vertices; every edge is shared by two faces.
    task automatic send_tetra(input logic [15:0] v0, input logic [15:0] v1,
                              input logic [15:0] v2, input logic [15:0] v3,
                              input logic last);
        send_face(v0, v1, v2, 1'b0);
        send_face(v0, v3, v1, 1'b0);
        send_face(v1, v3, v2, 1'b0);
        send_face(v2, v3, v0, last);
    endtask

    task automatic send_random_mesh();
        int            kind;
        int            parts;
        logic [15:0]   base;
        logic [15:0]   spread;
        kind  = int'($urandom_range(9));
        parts = int'($urandom_range(1, 4));
        base  = 16'($urandom);
        for (int p = 0; p < parts; p++)
        begin
            if (kind < 5)
            begin
                // well-formed closed pieces, possibly sharing vertices
                send_tetra(base + 16'(p * 3), base + 16'(p * 3 + 1),
                           base + 16'(p * 3 + 2), 16'($urandom), p == parts - 1);
            end
            else if (kind < 7)
            begin
                // open fan around one hub: boundary rim, shared spokes
                for (int k = 0; k < 4; k++)
                begin
                    send_face(base, base + 16'(k + 1), base + 16'(k + 2),
                              (p == parts - 1) && (k == 3));
                end
            end
            else
            begin
                // noise over a small vertex pool: repeats, degenerate and
                // over-used edges all show up
                spread = 16'($urandom_range(2, 12));
                for (int k = 0; k < 3; k++)
                begin
                    send_face(base + 16'($urandom_range(spread)),
                              base + 16'($urandom_range(spread)),
                              base + 16'($urandom_range(spread)),
                              (p == parts - 1) && (k == 2));
                end
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        quiet         = 1'b0;
        faces_sent    = 0;
        face_ch.valid = 1'b0;
        face_ch.data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of the index range and a closed solid.
        send_tetra(16'd0, 16'd1, 16'd65535, 16'd32768, 1'b1);
        send_face(16'hFFFF, 16'h0000, 16'hAAAA, 1'b1);
        send_face(16'h5555, 16'hFFFF, 16'h0000, 1'b1);
        // Repeated corners: degenerate edges still count.
        send_face(16'd5, 16'd5, 16'd5, 1'b1);
        send_face(16'd9, 16'd9, 16'd20, 1'b1);
        // Use count saturation: same face four times, then a fifth.
        repeat (4) send_face(16'd100, 16'd200, 16'd300, 1'b0);
        send_face(16'd300, 16'd100, 16'd200, 1'b1);
        // Two faces sharing one edge; the second closes the mesh with last.
        send_face(16'd7, 16'd8, 16'd9, 1'b0);
        send_face(16'd9, 16'd8, 16'd10, 1'b1);

        // Random meshes, with one long stretch of no idling and a window of drain pauses.
        while (faces_sent < RANDOM_ITEMS)
        begin
            quiet = (faces_sent >= 250) && (faces_sent < 380);
            if (faces_sent >= 450 && faces_sent < 470)
            begin
                face_ch.valid <= 1'b0;
                while (pending != 0) @(posedge clk);
                repeat (SWEEP_CYCLES + 16) @(posedge clk);
            end
            send_random_mesh();
        end
        quiet = 1'b0;

        // A lone face after the last mesh: the cleared table starts empty.
        send_face(16'd1, 16'd2, 16'd3, 1'b1);

        face_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SWEEP_CYCLES + 64) @(posedge clk);

        $display("covered %0d triangles in %0d meshes; %0d mesh(es) overflowed the edge table",
                 faces_sent, summaries_seen, overflow_meshes);
        if (errors == 0)
        begin
            $display("triangle_edge_manifold_stats_unit_test: clean");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("triangle_edge_manifold_stats_unit_test: errors");
        end
        $finish;
    end

endmodule
